[rtl/core/tfs_pkg.sv]
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the timed frame sequencer.
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int TIME_W     = 32;
	localparam int DUR_W      = 16;
	localparam int TGT_W      = 4;
	localparam int CMD_W      = 2;
	localparam int SHOW_W     = 4;
	localparam int FCNT_W     = 5;
	localparam int CFG_W      = 16;

	localparam int IN_BITS    = TIME_W + TGT_W + DUR_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = SHOW_W + 1 + 1 + FCNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_JUMP   = 2'd1,
		CMD_APPEND = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_LOOP     = 2'd0,
		MODE_ONCE     = 2'd1,
		MODE_HOLD     = 2'd2,
		MODE_PINGPONG = 2'd3
	} mode_t;

	typedef enum logic {
		CFG_PLAY_MODE   = 1'b0,
		CFG_DEFAULT_DUR = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [SHOW_W-1:0] shown_frame;
		logic              frame_shown;
		logic              finished;
		logic [FCNT_W-1:0] frame_count;
	} result_t;

endpackage

[rtl/core/tfs_seq.sv]
// ----------------------------------------------------------------------------
// tfs_seq
// Frame table, sequencing state and configuration; updates on each request.
// ----------------------------------------------------------------------------
module tfs_seq
	import tfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [CMD_W-1:0]  command,
	input  logic [TIME_W-1:0] now,
	input  logic [TGT_W-1:0]  frame_index,
	input  logic [DUR_W-1:0]  duration,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output result_t           res,
	output logic [CNT_W-1:0]  held_o,
	output logic [IDX_W-1:0]  idx_o,
	output logic              started_o
);

	logic [DUR_W-1:0]  dur_q [MAX_FRAMES];
	logic [CNT_W-1:0]  held_q, held_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              started_q, started_d;
	logic              done_q, done_d;
	logic              fwd_q, fwd_d;
	logic [TIME_W-1:0] lct_q, lct_d;
	mode_t             mode_q;
	logic [DUR_W-1:0]  def_dur_q;

	logic [IDX_W-1:0]  eff_idx;
	logic [TIME_W-1:0] eff_lct;
	logic              eff_done;
	logic [TIME_W-1:0] elapsed;
	logic [CNT_W-1:0]  c_ext, c_inc, last;
	logic              adv;
	logic              shown;
	logic              do_append;
	logic [DUR_W-1:0]  app_dur;
	cmd_t              cmd;

	assign cmd      = cmd_t'(command);
	assign eff_idx  = started_q ? idx_q : '0;
	assign eff_lct  = started_q ? lct_q : now;
	assign eff_done = started_q ? done_q : 1'b0;
	assign elapsed  = now - eff_lct;
	assign c_ext    = {{(CNT_W-IDX_W){1'b0}}, eff_idx};
	assign c_inc    = c_ext + CNT_W'(1);
	assign last     = held_q - CNT_W'(1);
	assign adv      = !eff_done && (c_ext < held_q)
	                  && (elapsed > {{(TIME_W-DUR_W){1'b0}}, dur_q[eff_idx]});
	assign do_append = (cmd == CMD_APPEND) && (held_q < CNT_W'(MAX_FRAMES));
	assign app_dur   = (duration == '0) ? def_dur_q : duration;

	always_comb begin
		held_d    = held_q;
		idx_d     = idx_q;
		started_d = started_q;
		done_d    = done_q;
		fwd_d     = fwd_q;
		lct_d     = lct_q;
		shown     = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (held_q != '0) begin
					shown     = 1'b1;
					started_d = 1'b1;
					idx_d     = eff_idx;
					lct_d     = eff_lct;
					done_d    = eff_done;
					if (adv) begin
						lct_d = now;
						case (mode_q)
							MODE_LOOP: begin
								idx_d = (c_inc >= held_q) ? '0 : c_inc[IDX_W-1:0];
							end
							MODE_ONCE: begin
								if (c_inc >= held_q) begin
									idx_d  = '0;
									done_d = 1'b1;
								end else begin
									idx_d = c_inc[IDX_W-1:0];
								end
							end
							MODE_HOLD: begin
								if (c_inc >= held_q) begin
									idx_d  = last[IDX_W-1:0];
									done_d = 1'b1;
								end else begin
									idx_d = c_inc[IDX_W-1:0];
								end
							end
							MODE_PINGPONG: begin
								if (fwd_q) begin
									if (c_inc >= last) begin
										idx_d = last[IDX_W-1:0];
										fwd_d = 1'b0;
									end else begin
										idx_d = c_inc[IDX_W-1:0];
									end
								end else begin
									if (c_ext <= CNT_W'(1)) begin
										idx_d = '0;
										fwd_d = 1'b1;
									end else begin
										idx_d = eff_idx - IDX_W'(1);
									end
								end
							end
							default: idx_d = eff_idx;
						endcase
					end
				end
			end
			CMD_JUMP: begin
				if ({{(CNT_W-TGT_W){1'b0}}, frame_index} < held_q) begin
					idx_d     = frame_index[IDX_W-1:0];
					lct_d     = now;
					done_d    = 1'b0;
					started_d = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (do_append) begin
					held_d = held_q + CNT_W'(1);
				end
			end
			default: held_d = held_q;
		endcase
	end

	always_comb begin
		res.shown_frame = SHOW_W'(idx_d);
		res.frame_shown = shown;
		res.finished    = done_d;
		res.frame_count = FCNT_W'(held_d);
	end

	assign held_o    = held_q;
	assign idx_o     = idx_q;
	assign started_o = started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			idx_q     <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			fwd_q     <= 1'b1;
			lct_q     <= '0;
		end else if (en) begin
			held_q    <= held_d;
			idx_q     <= idx_d;
			started_q <= started_d;
			done_q    <= done_d;
			fwd_q     <= fwd_d;
			lct_q     <= lct_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && do_append) begin
			dur_q[held_q[IDX_W-1:0]] <= app_dur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LOOP;
			def_dur_q <= DUR_W'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLAY_MODE:   mode_q    <= mode_t'(cfg_data[1:0]);
				CFG_DEFAULT_DUR: def_dur_q <= cfg_data[DUR_W-1:0];
				default:         mode_q    <= mode_q;
			endcase
		end
	end

endmodule

[rtl/core/timed_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// timed_frame_sequencer
// Animation frame sequencer with per-frame durations and four play modes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the command (tick,
//   jump, append), s_tdata carries now, frame_index and duration.
//   Every request yields exactly one result on the m_ stream: the frame
//   to show, a shown flag, the finished flag and the frame count.
//   Configuration (play mode, default duration) is written through
//   cfg_we / cfg_index / cfg_data while no request is in flight.
//   The result is registered and is valid in the cycle after the request
//   is taken. Throughput: one request per cycle while s_tready is high;
//   the state update for a request is a single pass of subtract, compare
//   and index step from the state registers into the result register.
//   Reset empties the frame table, stops the sequence, sets play mode to
//   loop and default duration to 100 ticks.
//   When m_tready is low a result holds in the output register; s_tready
//   stays high while that register is empty or is being drained.
// ----------------------------------------------------------------------------
module timed_frame_sequencer
	import tfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] now, [35:32] frame_index, [51:36] duration, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] command
	input  logic [CMD_W-1:0]      s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [3:0] shown_frame, [4] frame_shown, [5] finished, [10:6] frame_count
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic                  accept;
	result_t               res;
	logic                  m_tvalid_q;
	result_t               m_res_q;
	logic [CNT_W-1:0]      held;
	logic [IDX_W-1:0]      idx;
	logic                  started;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	tfs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.command     (s_tuser),
		.now         (s_tdata[TIME_W-1:0]),
		.frame_index (s_tdata[TIME_W+TGT_W-1:TIME_W]),
		.duration    (s_tdata[IN_BITS-1:TIME_W+TGT_W]),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_idx_t'(cfg_index)),
		.cfg_data    (cfg_data),
		.res         (res),
		.held_o      (held),
		.idx_o       (idx),
		.started_o   (started)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, m_res_q.frame_count,
	                   m_res_q.finished, m_res_q.frame_shown, m_res_q.shown_frame};

	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held <= CNT_W'(MAX_FRAMES))
		else $error("frame count above table size");

	a_idx_valid: assert property (@(posedge clk) disable iff (!arst_n)
		started |-> ({{(CNT_W-IDX_W){1'b0}}, idx} < held))
		else $error("current frame outside table");

	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted request gave no result");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_res_q.frame_count == FCNT_W'(held)))
		else $error("reported frame count differs from table");

endmodule

[tb/sv/frame_seq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_seq_checker
// Watches the request, result and configuration ports of the timed frame
// sequencer. It keeps its own copy of the frame table, the play state and the
// settings, works out the display state that each request leaves, and
// compares every result with the oldest display still owed.
// ----------------------------------------------------------------------------
module frame_seq_checker
	import tfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output int                    fail_count,
	output int                    pending
);

	logic [DUR_W-1:0]  dur_tab [MAX_FRAMES];
	logic [FCNT_W-1:0] held;
	logic [IDX_W-1:0]  cur;
	logic              started;
	logic              done;
	logic              fwd;
	logic [TIME_W-1:0] last_t;
	mode_t             play_mode_r;
	logic [DUR_W-1:0]  def_dur;

	result_t display_q [$];
	int      results_seen;

	task automatic flag_error(input string msg);
		if (fail_count < 10)
			$display("ERROR: %s", msg);
		fail_count++;
	endtask

	task automatic sequencer_step(
		input  logic [CMD_W-1:0]  cmd,
		input  logic [TIME_W-1:0] t,
		input  logic [TGT_W-1:0]  tgt,
		input  logic [DUR_W-1:0]  d,
		output result_t           r
	);
		int                n;
		int                c;
		logic [TIME_W-1:0] elapsed;
		r.frame_shown = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (held != 0) begin
					if (!started) begin
						started = 1'b1;
						cur     = '0;
						last_t  = t;
						done    = 1'b0;
					end
					elapsed = t - last_t;
					if (!done && cur < held && elapsed > {16'b0, dur_tab[cur]}) begin
						last_t = t;
						n = int'(held);
						c = int'(cur);
						case (play_mode_r)
							MODE_LOOP: begin
								c++;
								if (c >= n)
									c = 0;
							end
							MODE_ONCE: begin
								c++;
								if (c >= n) begin
									c    = 0;
									done = 1'b1;
								end
							end
							MODE_HOLD: begin
								c++;
								if (c >= n) begin
									c    = n - 1;
									done = 1'b1;
								end
							end
							default: begin
								if (fwd) begin
									c++;
									if (c >= n - 1) begin
										fwd = 1'b0;
										c   = n - 1;
									end
								end else begin
									c--;
									if (c <= 0) begin
										fwd = 1'b1;
										c   = 0;
									end
								end
							end
						endcase
						if (c < 0)
							c = 0;
						cur = IDX_W'(c);
					end
					r.frame_shown = 1'b1;
				end
			end
			CMD_JUMP: begin
				if (tgt < held) begin
					cur     = tgt;
					last_t  = t;
					done    = 1'b0;
					started = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (held < MAX_FRAMES) begin
					dur_tab[held[IDX_W-1:0]] = (d == 0) ? def_dur : d;
					held++;
				end
			end
			default: ;
		endcase
		r.shown_frame = cur;
		r.finished    = done;
		r.frame_count = held;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			foreach (dur_tab[i])
				dur_tab[i] = '0;
			held         = '0;
			cur          = '0;
			started      = 1'b0;
			done         = 1'b0;
			fwd          = 1'b1;
			last_t       = '0;
			play_mode_r  = MODE_LOOP;
			def_dur      = 16'd100;
			display_q.delete();
			results_seen = 0;
			fail_count   = 0;
			pending      = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.shown_frame = m_tdata[3:0];
				got.frame_shown = m_tdata[4];
				got.finished    = m_tdata[5];
				got.frame_count = m_tdata[10:6];
				if (display_q.size() == 0) begin
					flag_error($sformatf("result %0d arrived with no request owed: %h",
						results_seen, m_tdata));
				end else begin
					want = display_q.pop_front();
					if (got.shown_frame != want.shown_frame ||
						got.frame_shown != want.frame_shown ||
						got.finished != want.finished ||
						got.frame_count != want.frame_count)
						flag_error($sformatf({"result %0d: frame %0d shown %b done %b count %0d,",
							" want frame %0d shown %b done %b count %0d"}, results_seen,
							got.shown_frame, got.frame_shown, got.finished, got.frame_count,
							want.shown_frame, want.frame_shown, want.finished,
							want.frame_count));
				end
				results_seen++;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_PLAY_MODE)
					play_mode_r = mode_t'(cfg_data[1:0]);
				else
					def_dur = cfg_data[DUR_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				sequencer_step(s_tuser, s_tdata[31:0], s_tdata[35:32], s_tdata[51:36], want);
				display_q.insert(display_q.size(), want);
			end
			pending = display_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the timed frame sequencer: a directed opening over the empty
// table, time wrap, duration extremes and every play mode, then random
// phases of ticks, jumps and appends under changing settings, with random
// idling on both streams, a long result stall and drains between phases.
// ----------------------------------------------------------------------------
module tb;
	import tfs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 200;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = CFG_PLAY_MODE;
	logic [CFG_W-1:0]      cfg_data  = '0;

	int fail_count;
	int pending;
	bit no_gaps = 1'b0;
	bit hold_rx = 1'b0;

	always #10 clk = ~clk;

	timed_frame_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frame_seq_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			m_tready <= no_gaps || ($urandom_range(0, 99) >= 27);
		end
	end

	task automatic send_request(
		input logic [CMD_W-1:0]  cmd,
		input logic [TIME_W-1:0] t,
		input logic [TGT_W-1:0]  idx,
		input logic [DUR_W-1:0]  d
	);
		while (!no_gaps && $urandom_range(0, 99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_DATA_W - 52){1'b0}}, d, idx, t};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic load_settings(input mode_t mode, input logic [DUR_W-1:0] dflt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PLAY_MODE;
		cfg_data  <= CFG_W'(mode);
		@(posedge clk);
		cfg_index <= CFG_DEFAULT_DUR;
		cfg_data  <= dflt;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [TIME_W-1:0] anim_time;
		logic [DUR_W-1:0]  dur;
		logic [DUR_W-1:0]  dflt;
		logic [CMD_W-1:0]  cmd;
		mode_t             mode;
		int unsigned       pick;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, reset settings
		send_request(CMD_TICK, 32'd5, 4'd0, 16'd0);
		send_request(CMD_JUMP, 32'd7, 4'd0, 16'd0);
		send_request(CMD_UNUSED, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
		send_request(CMD_APPEND, 32'd0, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd1000, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd1100, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd1101, 4'd0, 16'd0);
		drain();
		load_settings(MODE_PINGPONG, 16'd0);
		send_request(CMD_TICK, 32'd1300, 4'd0, 16'd0);
		send_request(CMD_APPEND, 32'd0, 4'd0, 16'd0);
		send_request(CMD_APPEND, 32'd0, 4'd0, 16'hFFFF);
		send_request(CMD_JUMP, 32'd2000, 4'hF, 16'd0);
		send_request(CMD_JUMP, 32'hFFFF_FFFE, 4'd1, 16'd0);
		send_request(CMD_TICK, 32'hFFFF_FFFE, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd1, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd2, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd65538, 4'd0, 16'd0);
		drain();
		load_settings(MODE_ONCE, 16'hFFFF);
		send_request(CMD_JUMP, 32'd10, 4'd1, 16'd0);
		send_request(CMD_TICK, 32'd12, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd70000, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd200000, 4'd0, 16'd0);
		drain();
		load_settings(MODE_HOLD, 16'd1);
		send_request(CMD_JUMP, 32'd300000, 4'd1, 16'd0);
		send_request(CMD_TICK, 32'd300001, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd400000, 4'd0, 16'd0);
		send_request(CMD_TICK, 32'd500000, 4'd0, 16'd0);

		anim_time = 32'd500000;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			mode = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(0, 3));
			if (p == 1)
				dflt = 16'd0;
			else if (p == 2)
				dflt = 16'hFFFF;
			else if ($urandom_range(0, 3) == 0)
				dflt = DUR_W'($urandom_range(0, 65535));
			else
				dflt = DUR_W'($urandom_range(1, 20));
			load_settings(mode, dflt);
			no_gaps = (p == 3);
			if (p == 5)
				hold_rx = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					anim_time += $urandom_range(0, 8);
				else if (pick < 92)
					anim_time += $urandom_range(0, 40);
				else if (pick < 97)
					anim_time += $urandom_range(0, 70000);
				else
					anim_time = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 55)
					dur = DUR_W'($urandom_range(0, 12));
				else if (pick < 85)
					dur = DUR_W'($urandom_range(13, 300));
				else
					dur = DUR_W'($urandom_range(0, 65535));
				pick = $urandom_range(0, 99);
				if (pick < 3)
					cmd = CMD_APPEND;
				else if (pick < 13)
					cmd = CMD_JUMP;
				else if (pick < 15)
					cmd = CMD_UNUSED;
				else
					cmd = CMD_TICK;
				send_request(cmd, anim_time, 4'($urandom_range(0, 15)), dur);
			end
		end
		drain();

		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/core/tfs_pkg.sv
rtl/core/tfs_seq.sv
rtl/core/timed_frame_sequencer.sv
tb/sv/frame_seq_checker.sv
tb/sv/tb.sv
